/* rtl/euler_to_quaternion_core_defines.svh */
// Assertion macros for the euler_to_quaternion core.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef EULER_TO_QUATERNION_CORE_DEFINES_SVH
`define EULER_TO_QUATERNION_CORE_DEFINES_SVH

// same-cycle implication
`define E2Q_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define E2Q_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/e2q_pkg.sv */
// Shared widths, constants and tables for the euler_to_quaternion core.
// No dependencies.
package e2q_pkg;

    localparam int ANG_W      = 18;
    localparam int TW_W       = 20;
    localparam int HW_W       = 17;
    localparam int MAG_W      = 15;
    localparam int Q_W        = 10;
    localparam int R_W        = 6;
    localparam int MZ_W       = 31;
    localparam int Z_W        = 33;
    localparam int XY_W       = 34;
    localparam int SC_W       = 17;
    localparam int PROD_W     = 34;
    localparam int TRI_W      = 51;
    localparam int SUM_W      = 52;
    localparam int OUT_W      = 16;
    localparam int IN_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PREP_STAGES = 3;
    localparam int COMB_STAGES = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_OFS = 2'd1;

    localparam logic signed [ANG_W-1:0] NINETY_Q7 = 18'sd11520;
    localparam logic signed [TW_W-1:0] HALF_TURN_Q8    = 20'sd46080;
    localparam logic signed [TW_W-1:0] FULL_TURN_Q8    = 20'sd92160;
    localparam logic signed [TW_W-1:0] QUARTER_TURN_Q8 = 20'sd23040;

    // floor(mag/45) via reciprocal, then one correction step
    localparam logic [11:0] RECIP_45 = 12'd2912;
    localparam int RECIP_SH = 17;
    localparam logic [15:0] DIV_45 = 16'd45;
    localparam logic [MZ_W-1:0] FRAC_MUL = 31'd46603;

    localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [OUT_W-1:0] ONE_Q14 = 16'sd16384;

    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        logic signed [Z_W-1:0] v;
        begin
            unique case (idx)
                0:  v = 33'sh020000000;
                1:  v = 33'sh012E4051D;
                2:  v = 33'sh009FB385B;
                3:  v = 33'sh0051111D4;
                4:  v = 33'sh0028B0D43;
                5:  v = 33'sh00145D7E1;
                6:  v = 33'sh000A2F61E;
                7:  v = 33'sh000517C55;
                8:  v = 33'sh00028BE53;
                9:  v = 33'sh000145F2F;
                10: v = 33'sh0000A2F98;
                11: v = 33'sh0000517CC;
                12: v = 33'sh000028BE6;
                13: v = 33'sh0000145F3;
                14: v = 33'sh00000A2F9;
                15: v = 33'sh00000517C;
                16: v = 33'sh0000028BE;
                17: v = 33'sh00000145F;
                18: v = 33'sh000000A2F;
                19: v = 33'sh000000517;
                20: v = 33'sh00000028B;
                21: v = 33'sh000000145;
                22: v = 33'sh0000000A2;
                23: v = 33'sh000000051;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // floor((17r + 22) / 45): remainder part of round(r * 2^21 / 45)
    function automatic logic [4:0] frac_corr(input logic [R_W-1:0] r);
        logic [4:0] c;
        begin
            unique case (r)
                6'd0,  6'd1:                      c = 5'd0;
                6'd2,  6'd3:                      c = 5'd1;
                6'd4,  6'd5,  6'd6:               c = 5'd2;
                6'd7,  6'd8,  6'd9:               c = 5'd3;
                6'd10, 6'd11:                     c = 5'd4;
                6'd12, 6'd13, 6'd14:              c = 5'd5;
                6'd15, 6'd16, 6'd17:              c = 5'd6;
                6'd18, 6'd19:                     c = 5'd7;
                6'd20, 6'd21, 6'd22:              c = 5'd8;
                6'd23, 6'd24, 6'd25:              c = 5'd9;
                6'd26, 6'd27:                     c = 5'd10;
                6'd28, 6'd29, 6'd30:              c = 5'd11;
                6'd31, 6'd32, 6'd33:              c = 5'd12;
                6'd34, 6'd35:                     c = 5'd13;
                6'd36, 6'd37, 6'd38:              c = 5'd14;
                6'd39, 6'd40, 6'd41:              c = 5'd15;
                6'd42, 6'd43:                     c = 5'd16;
                6'd44:                            c = 5'd17;
                default:                          c = 5'd0;
            endcase
            return c;
        end
    endfunction

endpackage

/* rtl/e2q_prep.sv */
// Angle preparation lane: wrap to a half turn, fold to a quarter turn, scale
// to a binary angle. Three register stages. Uses e2q_pkg.
module e2q_prep
(
    input  logic                                   clk,
    input  logic [e2q_pkg::PREP_STAGES-1:0]        en,
    input  logic signed [e2q_pkg::ANG_W-1:0]       angle,
    output logic signed [e2q_pkg::Z_W-1:0]         z_out,
    output logic                                   flip_out
);

    // stage 1: wrap into [-180, 180) degrees
    logic signed [e2q_pkg::TW_W-1:0] t_ext;
    logic signed [e2q_pkg::TW_W-1:0] t_wrap;
    logic signed [e2q_pkg::TW_W-1:0] t_hw;
    logic signed [e2q_pkg::HW_W-1:0] hw_next;
    logic signed [e2q_pkg::HW_W-1:0] hw_reg;

    always_comb
    begin
        t_ext = e2q_pkg::TW_W'(angle) + e2q_pkg::HALF_TURN_Q8;
        priority if (t_ext < 0)
        begin
            t_wrap = t_ext + e2q_pkg::FULL_TURN_Q8;
        end
        else if (t_ext >= e2q_pkg::FULL_TURN_Q8)
        begin
            t_wrap = t_ext - e2q_pkg::FULL_TURN_Q8;
        end
        else
        begin
            t_wrap = t_ext;
        end
        t_hw    = t_wrap - e2q_pkg::HALF_TURN_Q8;
        hw_next = $signed(t_hw[e2q_pkg::HW_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hw_reg <= hw_next;
        end
    end

    // stage 2: fold to +-90 degrees, magnitude, coarse quotient by 45
    logic signed [e2q_pkg::TW_W-1:0] hw_ext;
    logic signed [e2q_pkg::TW_W-1:0] h2;
    logic [e2q_pkg::TW_W-1:0]        h2_abs;
    logic                            flip_next;
    logic [e2q_pkg::MAG_W-1:0]       mag_next;
    logic [26:0]                     q0_prod;
    logic [e2q_pkg::MAG_W-1:0]       mag_reg;
    logic [e2q_pkg::Q_W-1:0]         q0_reg;
    logic                            neg_reg;
    logic                            flip2_reg;

    always_comb
    begin
        hw_ext = e2q_pkg::TW_W'(hw_reg);
        priority if (hw_ext > e2q_pkg::QUARTER_TURN_Q8)
        begin
            h2        = hw_ext - e2q_pkg::HALF_TURN_Q8;
            flip_next = 1'b1;
        end
        else if (hw_ext < -e2q_pkg::QUARTER_TURN_Q8)
        begin
            h2        = hw_ext + e2q_pkg::HALF_TURN_Q8;
            flip_next = 1'b1;
        end
        else
        begin
            h2        = hw_ext;
            flip_next = 1'b0;
        end
        h2_abs   = (h2 < 0) ? e2q_pkg::TW_W'(-h2) : e2q_pkg::TW_W'(h2);
        mag_next = h2_abs[e2q_pkg::MAG_W-1:0];
        q0_prod  = 27'(mag_next) * 27'(e2q_pkg::RECIP_45);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mag_reg   <= mag_next;
            q0_reg    <= q0_prod[e2q_pkg::RECIP_SH +: e2q_pkg::Q_W];
            neg_reg   <= (h2 < 0);
            flip2_reg <= flip_next;
        end
    end

    // stage 3: correct quotient, add remainder table, apply sign
    logic [15:0]                     m45;
    logic [15:0]                     r0;
    logic [e2q_pkg::Q_W-1:0]         q_fix;
    logic [e2q_pkg::R_W-1:0]         r_fix;
    logic [e2q_pkg::MZ_W-1:0]        magz;
    logic signed [e2q_pkg::Z_W-1:0]  z_pos;
    logic signed [e2q_pkg::Z_W-1:0]  z_next;

    always_comb
    begin
        m45 = 16'(q0_reg) * e2q_pkg::DIV_45;
        r0  = 16'(mag_reg) - m45;
        if (r0 >= e2q_pkg::DIV_45)
        begin
            q_fix = q0_reg + 1'b1;
            r_fix = e2q_pkg::R_W'(r0 - e2q_pkg::DIV_45);
        end
        else
        begin
            q_fix = q0_reg;
            r_fix = e2q_pkg::R_W'(r0);
        end
        magz = {q_fix, 21'd0} + e2q_pkg::MZ_W'(r_fix) * e2q_pkg::FRAC_MUL
             + e2q_pkg::MZ_W'(e2q_pkg::frac_corr(r_fix));
        z_pos  = $signed({2'b00, magz});
        z_next = neg_reg ? -z_pos : z_pos;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            z_out    <= z_next;
            flip_out <= flip2_reg;
        end
    end

endmodule

/* rtl/e2q_cordic.sv */
// Pipelined rotation-mode CORDIC: one stage per step plus a rounding stage
// giving Q15 cosine and sine. Uses e2q_pkg.
module e2q_cordic #(
    parameter int STEPS = 16
)
(
    input  logic                                clk,
    input  logic [STEPS:0]                      en,
    input  logic signed [e2q_pkg::Z_W-1:0]      z_in,
    input  logic                                flip_in,
    output logic signed [e2q_pkg::SC_W-1:0]     cos_out,
    output logic signed [e2q_pkg::SC_W-1:0]     sin_out
);

    localparam logic signed [e2q_pkg::XY_W-1:0] RND_Q15 = 34'sd16384;

    logic signed [e2q_pkg::XY_W-1:0] x_reg [STEPS];
    logic signed [e2q_pkg::XY_W-1:0] y_reg [STEPS];
    logic signed [e2q_pkg::Z_W-1:0]  z_reg [STEPS];
    logic                            flip_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [e2q_pkg::XY_W-1:0] x_prev;
        logic signed [e2q_pkg::XY_W-1:0] y_prev;
        logic signed [e2q_pkg::Z_W-1:0]  z_prev;
        logic                            f_prev;
        logic signed [e2q_pkg::XY_W-1:0] x_next;
        logic signed [e2q_pkg::XY_W-1:0] y_next;
        logic signed [e2q_pkg::Z_W-1:0]  z_next;

        if (i == 0)
        begin : g_init
            assign x_prev = e2q_pkg::GAIN_Q30;
            assign y_prev = '0;
            assign z_prev = z_in;
            assign f_prev = flip_in;
        end
        else
        begin : g_chain
            assign x_prev = x_reg[i-1];
            assign y_prev = y_reg[i-1];
            assign z_prev = z_reg[i-1];
            assign f_prev = flip_reg[i-1];
        end

        always_comb
        begin
            if (z_prev >= 0)
            begin
                x_next = x_prev - (y_prev >>> i);
                y_next = y_prev + (x_prev >>> i);
                z_next = z_prev - e2q_pkg::atan_entry(i);
            end
            else
            begin
                x_next = x_prev + (y_prev >>> i);
                y_next = y_prev - (x_prev >>> i);
                z_next = z_prev + e2q_pkg::atan_entry(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                flip_reg[i] <= f_prev;
            end
        end
    end

    logic signed [e2q_pkg::XY_W-1:0] x_rnd;
    logic signed [e2q_pkg::XY_W-1:0] y_rnd;
    logic signed [e2q_pkg::SC_W-1:0] c_q15;
    logic signed [e2q_pkg::SC_W-1:0] s_q15;
    logic signed [e2q_pkg::SC_W-1:0] cos_next;
    logic signed [e2q_pkg::SC_W-1:0] sin_next;

    always_comb
    begin
        x_rnd    = (x_reg[STEPS-1] + RND_Q15) >>> 15;
        y_rnd    = (y_reg[STEPS-1] + RND_Q15) >>> 15;
        c_q15    = $signed(x_rnd[e2q_pkg::SC_W-1:0]);
        s_q15    = $signed(y_rnd[e2q_pkg::SC_W-1:0]);
        cos_next = flip_reg[STEPS-1] ? -c_q15 : c_q15;
        sin_next = flip_reg[STEPS-1] ? -s_q15 : s_q15;
    end

    always_ff @(posedge clk)
    begin
        if (en[STEPS])
        begin
            cos_out <= cos_next;
            sin_out <= sin_next;
        end
    end

endmodule

/* rtl/e2q_combine.sv */
// Quaternion assembly: pair products, triple products, then sum, round and
// saturate to Q2.14. Three register stages. Uses e2q_pkg.
module e2q_combine
(
    input  logic                                   clk,
    input  logic [e2q_pkg::COMB_STAGES-1:0]        en,
    input  logic signed [e2q_pkg::SC_W-1:0]        cr,
    input  logic signed [e2q_pkg::SC_W-1:0]        sr,
    input  logic signed [e2q_pkg::SC_W-1:0]        cp,
    input  logic signed [e2q_pkg::SC_W-1:0]        sp,
    input  logic signed [e2q_pkg::SC_W-1:0]        cy,
    input  logic signed [e2q_pkg::SC_W-1:0]        sy,
    output logic signed [e2q_pkg::OUT_W-1:0]       quat_w,
    output logic signed [e2q_pkg::OUT_W-1:0]       quat_x,
    output logic signed [e2q_pkg::OUT_W-1:0]       quat_y,
    output logic signed [e2q_pkg::OUT_W-1:0]       quat_z
);

    localparam logic signed [e2q_pkg::SUM_W-1:0] RND_Q31 = 52'sd1073741824;

    function automatic logic signed [e2q_pkg::OUT_W-1:0] to_q14(
        input logic signed [e2q_pkg::SUM_W-1:0] s
    );
        logic signed [e2q_pkg::SUM_W-1:0] v;
        logic signed [e2q_pkg::SUM_W-1:0] lim;
        begin
            v   = (s + RND_Q31) >>> 31;
            lim = e2q_pkg::SUM_W'(e2q_pkg::ONE_Q14);
            priority if (v > lim)
            begin
                return e2q_pkg::ONE_Q14;
            end
            else if (v < -lim)
            begin
                return -e2q_pkg::ONE_Q14;
            end
            else
            begin
                return $signed(v[e2q_pkg::OUT_W-1:0]);
            end
        end
    endfunction

    // stage A
    logic signed [e2q_pkg::PROD_W-1:0] cc_reg, ss_reg, sc_reg, cs_reg;
    logic signed [e2q_pkg::SC_W-1:0]   cy_reg, sy_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cc_reg <= e2q_pkg::PROD_W'(cr) * e2q_pkg::PROD_W'(cp);
            ss_reg <= e2q_pkg::PROD_W'(sr) * e2q_pkg::PROD_W'(sp);
            sc_reg <= e2q_pkg::PROD_W'(sr) * e2q_pkg::PROD_W'(cp);
            cs_reg <= e2q_pkg::PROD_W'(cr) * e2q_pkg::PROD_W'(sp);
            cy_reg <= cy;
            sy_reg <= sy;
        end
    end

    // stage B
    logic signed [e2q_pkg::TRI_W-1:0] w1_reg, w2_reg, x1_reg, x2_reg;
    logic signed [e2q_pkg::TRI_W-1:0] y1_reg, y2_reg, z1_reg, z2_reg;
    logic signed [e2q_pkg::TRI_W-1:0] cy_ext, sy_ext;

    assign cy_ext = e2q_pkg::TRI_W'(cy_reg);
    assign sy_ext = e2q_pkg::TRI_W'(sy_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            w1_reg <= e2q_pkg::TRI_W'(cc_reg) * cy_ext;
            w2_reg <= e2q_pkg::TRI_W'(ss_reg) * sy_ext;
            x1_reg <= e2q_pkg::TRI_W'(sc_reg) * cy_ext;
            x2_reg <= e2q_pkg::TRI_W'(cs_reg) * sy_ext;
            y1_reg <= e2q_pkg::TRI_W'(cs_reg) * cy_ext;
            y2_reg <= e2q_pkg::TRI_W'(sc_reg) * sy_ext;
            z1_reg <= e2q_pkg::TRI_W'(cc_reg) * sy_ext;
            z2_reg <= e2q_pkg::TRI_W'(ss_reg) * cy_ext;
        end
    end

    // stage C
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            quat_w <= to_q14(e2q_pkg::SUM_W'(w1_reg) + e2q_pkg::SUM_W'(w2_reg));
            quat_x <= to_q14(e2q_pkg::SUM_W'(x1_reg) - e2q_pkg::SUM_W'(x2_reg));
            quat_y <= to_q14(e2q_pkg::SUM_W'(y1_reg) + e2q_pkg::SUM_W'(y2_reg));
            quat_z <= to_q14(e2q_pkg::SUM_W'(z1_reg) - e2q_pkg::SUM_W'(z2_reg));
        end
    end

endmodule

/* rtl/euler_to_quaternion_core.sv */
// Roll/pitch/yaw (1/128 degree) to ZYX quaternion in Q2.14.
// Top level; uses e2q_pkg, e2q_prep, e2q_cordic, e2q_combine and the defines header.
//
// Input channel: in_valid/in_stall with roll_deg, pitch_deg, heading_deg.
// Output channel: out_valid/out_stall with quat_w, quat_x, quat_y, quat_z.
// Config channel: cfg_valid/cfg_ready, cfg_index 0 = remap enable,
// 1 = heading offset; other indexes are ignored. cfg_ready is always high.
// Pipeline: CORDIC_STEPS + 7 register stages: 3 angle-preparation
// stages, one stage per CORDIC step plus a rounding stage, and 3
// multiply/round stages.
// Throughput: one item per cycle while out_stall is low; every stage is a
// register with its own valid.
// A stage moves on when it is empty or the stage after it moves, so a stall
// on the output fills bubbles first; in_stall rises only once every stage
// holds an item and out_stall is high. The stalled output holds.
// Reset clears all valid bits and loads remap enable = 1, offset = 1024.
`include "euler_to_quaternion_core_defines.svh"

module euler_to_quaternion_core #(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [e2q_pkg::IN_W-1:0]         roll_deg,
    input  logic signed [e2q_pkg::IN_W-1:0]         pitch_deg,
    input  logic signed [e2q_pkg::IN_W-1:0]         heading_deg,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [e2q_pkg::OUT_W-1:0]        quat_w,
    output logic signed [e2q_pkg::OUT_W-1:0]        quat_x,
    output logic signed [e2q_pkg::OUT_W-1:0]        quat_y,
    output logic signed [e2q_pkg::OUT_W-1:0]        quat_z,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [e2q_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [e2q_pkg::CFG_DATA_W-1:0]          cfg_data
);

    localparam int CORD_ST = CORDIC_STEPS + 1;
    localparam int NS = e2q_pkg::PREP_STAGES + CORD_ST + e2q_pkg::COMB_STAGES;
    localparam int CNT_W = $clog2(NS + 1);

    // configuration
    logic                                remap_en_reg;
    logic signed [e2q_pkg::IN_W-1:0]     head_ofs_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remap_en_reg <= 1'b1;
            head_ofs_reg <= 16'sd1024;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == e2q_pkg::CFG_REMAP_EN)
            begin
                remap_en_reg <= cfg_data[0];
            end
            else if (cfg_index == e2q_pkg::CFG_HEAD_OFS)
            begin
                head_ofs_reg <= $signed(cfg_data);
            end
        end
    end

    // pipeline control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    assign en[NS-1] = !v_reg[NS-1] || !out_stall;
    for (genvar i = 0; i < NS - 1; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    always_comb
    begin
        v_next = v_reg;
        if (en[0])
        begin
            v_next[0] = in_valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (en[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];

    // heading remap
    logic signed [e2q_pkg::ANG_W-1:0] yaw_ang;
    logic signed [e2q_pkg::ANG_W-1:0] roll_ang;
    logic signed [e2q_pkg::ANG_W-1:0] pitch_ang;

    always_comb
    begin
        roll_ang  = e2q_pkg::ANG_W'(roll_deg);
        pitch_ang = e2q_pkg::ANG_W'(pitch_deg);
        if (remap_en_reg)
        begin
            yaw_ang = e2q_pkg::NINETY_Q7 - e2q_pkg::ANG_W'(heading_deg)
                    + e2q_pkg::ANG_W'(head_ofs_reg);
        end
        else
        begin
            yaw_ang = e2q_pkg::ANG_W'(heading_deg);
        end
    end

    // three angle lanes
    logic signed [e2q_pkg::Z_W-1:0]  z_r, z_p, z_y;
    logic                            f_r, f_p, f_y;
    logic signed [e2q_pkg::SC_W-1:0] cr, sr, cp, sp, cy, sy;

    e2q_prep u_prep_roll (
        .clk(clk), .en(en[0 +: e2q_pkg::PREP_STAGES]),
        .angle(roll_ang), .z_out(z_r), .flip_out(f_r)
    );
    e2q_prep u_prep_pitch (
        .clk(clk), .en(en[0 +: e2q_pkg::PREP_STAGES]),
        .angle(pitch_ang), .z_out(z_p), .flip_out(f_p)
    );
    e2q_prep u_prep_yaw (
        .clk(clk), .en(en[0 +: e2q_pkg::PREP_STAGES]),
        .angle(yaw_ang), .z_out(z_y), .flip_out(f_y)
    );

    e2q_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
        .clk(clk), .en(en[e2q_pkg::PREP_STAGES +: CORD_ST]),
        .z_in(z_r), .flip_in(f_r), .cos_out(cr), .sin_out(sr)
    );
    e2q_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .clk(clk), .en(en[e2q_pkg::PREP_STAGES +: CORD_ST]),
        .z_in(z_p), .flip_in(f_p), .cos_out(cp), .sin_out(sp)
    );
    e2q_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
        .clk(clk), .en(en[e2q_pkg::PREP_STAGES +: CORD_ST]),
        .z_in(z_y), .flip_in(f_y), .cos_out(cy), .sin_out(sy)
    );

    e2q_combine u_combine (
        .clk(clk), .en(en[e2q_pkg::PREP_STAGES + CORD_ST +: e2q_pkg::COMB_STAGES]),
        .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
    );

    // checks
    logic             in_acc;
    logic [CNT_W-1:0] v_count;
    logic             quat_ok;

    assign in_acc  = in_valid && !in_stall;
    assign v_count = CNT_W'($countones(v_reg));
    assign quat_ok = (quat_w <= e2q_pkg::ONE_Q14) && (quat_w >= -e2q_pkg::ONE_Q14)
                  && (quat_x <= e2q_pkg::ONE_Q14) && (quat_x >= -e2q_pkg::ONE_Q14)
                  && (quat_y <= e2q_pkg::ONE_Q14) && (quat_y >= -e2q_pkg::ONE_Q14)
                  && (quat_z <= e2q_pkg::ONE_Q14) && (quat_z >= -e2q_pkg::ONE_Q14);

    `E2Q_ASSERT_IMP(a_stall_only_full, in_stall, (&v_reg) && out_stall, "stall with room")
    `E2Q_ASSERT_IMP(a_quat_range, out_valid, quat_ok, "quaternion component out of range")
    `E2Q_ASSERT_NXT(a_no_new_items, !in_acc, v_count <= $past(v_count), "count grew, no accept")

endmodule

/* sim/tb_euler_to_quaternion_core.sv */
// Self-checking testbench for euler_to_quaternion_core: angle items in, quaternion items out.
// Depends on e2q_pkg and the core RTL. Holds its own fixed-point CORDIC predictor.
`timescale 1ns / 1ps

module tb_euler_to_quaternion_core;

    localparam int STEPS = 16;
    localparam int LATENCY = STEPS + 7;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic signed [e2q_pkg::IN_W-1:0] roll;
        logic signed [e2q_pkg::IN_W-1:0] pitch;
        logic signed [e2q_pkg::IN_W-1:0] yaw;
    } angles_t;

    typedef struct packed {
        logic signed [e2q_pkg::OUT_W-1:0] w;
        logic signed [e2q_pkg::OUT_W-1:0] x;
        logic signed [e2q_pkg::OUT_W-1:0] y;
        logic signed [e2q_pkg::OUT_W-1:0] z;
    } quat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [e2q_pkg::IN_W-1:0] roll_deg;
    logic signed [e2q_pkg::IN_W-1:0] pitch_deg;
    logic signed [e2q_pkg::IN_W-1:0] heading_deg;
    logic out_valid;
    logic out_stall;
    logic signed [e2q_pkg::OUT_W-1:0] quat_w;
    logic signed [e2q_pkg::OUT_W-1:0] quat_x;
    logic signed [e2q_pkg::OUT_W-1:0] quat_y;
    logic signed [e2q_pkg::OUT_W-1:0] quat_z;
    logic cfg_valid;
    logic cfg_ready;
    logic [e2q_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [e2q_pkg::CFG_DATA_W-1:0] cfg_data;

    angles_t pending_angles[$];
    quat_t expected_quats[$];
    bit remap_on;
    longint head_ofs_model;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_sender;
    int mismatches;
    int quiet_cycles;

    longint arctan_q32[24] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    euler_to_quaternion_core #(.CORDIC_STEPS(STEPS)) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // h in 1/256 degree; Q15 cosine and sine
    function automatic void half_trig(input longint h, output longint c, output longint s);
        bit flip;
        longint mag;
        longint z;
        longint xv;
        longint yv;
        longint dx;
        longint dy;
        flip = 1'b0;
        h = ((h + 46080) % 92160 + 92160) % 92160 - 46080;
        if (h > 23040)
        begin
            h -= 46080;
            flip = 1'b1;
        end
        else if (h < -23040)
        begin
            h += 46080;
            flip = 1'b1;
        end
        mag = (h < 0) ? -h : h;
        mag = (mag * (64'sd1 <<< 21) + 22) / 45;
        z = (h < 0) ? -mag : mag;
        xv = 652032874;
        yv = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (z >= 0)
            begin
                xv -= dx;
                yv += dy;
                z -= arctan_q32[i];
            end
            else
            begin
                xv += dx;
                yv -= dy;
                z += arctan_q32[i];
            end
        end
        xv = (xv + (64'sd1 <<< 14)) >>> 15;
        yv = (yv + (64'sd1 <<< 14)) >>> 15;
        c = flip ? -xv : xv;
        s = flip ? -yv : yv;
    endfunction

    function automatic logic signed [e2q_pkg::OUT_W-1:0] round_q14(input longint a,
                                                                   input longint b);
        longint v;
        v = (a + b + (64'sd1 <<< 30)) >>> 31;
        if (v > 16384)
            v = 16384;
        if (v < -16384)
            v = -16384;
        return v[e2q_pkg::OUT_W-1:0];
    endfunction

    function automatic quat_t predict_quat(input angles_t a);
        longint yaw;
        longint cr, sr, cp, sp, cy, sy;
        quat_t q;
        yaw = a.yaw;
        if (remap_on)
            yaw = 11520 - yaw + head_ofs_model;
        half_trig(longint'(a.roll), cr, sr);
        half_trig(longint'(a.pitch), cp, sp);
        half_trig(yaw, cy, sy);
        q.w = round_q14(cr * cp * cy, sr * sp * sy);
        q.x = round_q14(sr * cp * cy, -(cr * sp * sy));
        q.y = round_q14(cr * sp * cy, sr * cp * sy);
        q.z = round_q14(cr * cp * sy, -(sr * sp * cy));
        return q;
    endfunction

    function automatic logic signed [e2q_pkg::IN_W-1:0] rand_angle();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            return e2q_pkg::IN_W'($urandom_range(0, 46080) - 23040);
        if (pick < 95)
        begin
            case ($urandom_range(0, 5))
                0: return -16'sd23040;
                1: return 16'sd23040;
                2: return -16'sd11520;
                3: return 16'sd11520;
                4: return 16'sd0;
                default: return 16'sd23039;
            endcase
        end
        return e2q_pkg::IN_W'($urandom());
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            roll_deg <= '0;
            pitch_deg <= '0;
            heading_deg <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_quats.push_back(predict_quat({roll_deg, pitch_deg, heading_deg}));
            if (!in_valid || !in_stall)
            begin
                if (!hold_sender && pending_angles.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    angles_t a;
                    a = pending_angles.pop_front();
                    roll_deg <= a.roll;
                    pitch_deg <= a.pitch;
                    heading_deg <= a.yaw;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            if (out_valid && !out_stall)
            begin
                if (expected_quats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item w=%0d x=%0d y=%0d z=%0d",
                                 quat_w, quat_x, quat_y, quat_z);
                end
                else
                begin
                    quat_t e;
                    e = expected_quats.pop_front();
                    if (e.w !== quat_w || e.x !== quat_x || e.y !== quat_y || e.z !== quat_z)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp w=%0d x=%0d y=%0d z=%0d got %0d %0d %0d %0d",
                                     e.w, e.x, e.y, e.z, quat_w, quat_x, quat_y, quat_z);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready) ||
                (pending_angles.size() == 0 && expected_quats.size() == 0 && !in_valid))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_euler_to_quaternion_core NOT OK");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_angles.size() > 0 || in_valid || expected_quats.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [e2q_pkg::CFG_IDX_W-1:0] idx,
                             input logic [e2q_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == e2q_pkg::CFG_REMAP_EN)
            remap_on = val[0];
        else if (idx == e2q_pkg::CFG_HEAD_OFS)
            head_ofs_model = longint'($signed(val));
        cfg_valid <= 1'b0;
    endtask

    task automatic add_item(input logic signed [e2q_pkg::IN_W-1:0] r,
                            input logic signed [e2q_pkg::IN_W-1:0] p,
                            input logic signed [e2q_pkg::IN_W-1:0] y);
        angles_t a;
        a.roll = r;
        a.pitch = p;
        a.yaw = y;
        pending_angles.push_back(a);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
            add_item(rand_angle(), rand_angle(), rand_angle());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        remap_on = 1'b1;
        head_ofs_model = 1024;
        hold_sender = 1'b0;
        mismatches = 0;
        send_idle_pct = 31;
        recv_idle_pct = 78;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, quadrant edges, wrap beyond half a turn, every input bit
        add_item(0, 0, 0);
        add_item(16'sd23040, 16'sd23040, 16'sd23040);
        add_item(-16'sd23040, -16'sd23040, -16'sd23040);
        add_item(16'sd11520, -16'sd11520, 16'sd11521);
        add_item(-16'sd11521, 16'sd11519, -16'sd11520);
        add_item(16'sd32767, -16'sd32768, 16'sd32767);
        add_item(-16'sd32768, 16'sd32767, -16'sd32768);
        add_item(-16'sd1, 16'sd1, 16'sd12544);
        add_item(16'sd23039, -16'sd23039, 16'sd0);
        add_item(16'sh5555, 16'shAAAA, 16'sh5555);
        add_item(16'shAAAA, 16'sh5555, 16'shAAAA);
        add_random(400);
        // hold the sender until the pipeline is empty
        while (pending_angles.size() > 400 - 150)
            @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_quats.size() > 0)
            @(posedge clk);
        hold_sender = 1'b0;
        drain();

        write_reg(e2q_pkg::CFG_REMAP_EN, 16'hFFFE);
        write_reg(e2q_pkg::CFG_HEAD_OFS, 16'hA600);
        write_reg(2'd2, 16'h0001);
        write_reg(2'd3, 16'h7FFF);
        add_item(0, 0, 16'sd23040);
        add_item(0, 0, -16'sd23040);
        add_random(300);
        drain();

        send_idle_pct = 78;
        recv_idle_pct = 31;
        write_reg(e2q_pkg::CFG_REMAP_EN, 16'h0001);
        write_reg(e2q_pkg::CFG_HEAD_OFS, 16'sd23040);
        add_item(0, 0, -16'sd23040);
        add_item(16'sd100, -16'sd100, 16'sd32767);
        add_random(300);
        drain();

        write_reg(e2q_pkg::CFG_HEAD_OFS, -16'sd23040);
        add_item(0, 0, 16'sd23040);
        add_random(300);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(e2q_pkg::CFG_HEAD_OFS, 16'hFFFF);
        add_random(250);
        drain();

        write_reg(e2q_pkg::CFG_REMAP_EN, 16'h0000);
        write_reg(e2q_pkg::CFG_HEAD_OFS, 16'd0);
        add_random(250);
        drain();

        if (mismatches == 0)
            $display("tb_euler_to_quaternion_core OK");
        else
            $display("tb_euler_to_quaternion_core NOT OK");
        $finish;
    end

endmodule

/* euler_to_quaternion_core.f */
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_prep.sv
rtl/e2q_cordic.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion_core.sv
sim/tb_euler_to_quaternion_core.sv
